[hdl/blit_dma_path_planner_defines.svh]
// Assertion macros used by the checker file of the copy path planner.
`ifndef BLIT_DMA_PATH_PLANNER_DEFINES_SVH
`define BLIT_DMA_PATH_PLANNER_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define BDPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define BDPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/bdpp_pkg.sv]
package bdpp_pkg;

  // Alignment of DMA transfers, given as log2 of the byte count.
  localparam int unsigned IntAlignLg = 4;
  localparam int unsigned ExtAlignLg = 5;

  // Widths of the request and plan fields.
  localparam int unsigned AddrW  = 32;
  localparam int unsigned DimW   = 16;
  localparam int unsigned PlanW  = 4;
  localparam int unsigned SplitW = 5;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_ENGINE  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_ROW = 1'd1;

  localparam logic [DimW-1:0] MinRowReset = 16'd128;

  typedef enum logic [PlanW-1:0] {
    PLAN_IGNORED      = 4'd0,
    PLAN_NO_ENGINE    = 4'd1,
    PLAN_DMA_CONTIG   = 4'd2,
    PLAN_CONTIG_SPLIT = 4'd3,
    PLAN_SMALL_CONTIG = 4'd4,
    PLAN_MISALIGNED   = 4'd5,
    PLAN_NARROW_ROW   = 4'd6,
    PLAN_ROW_DMA      = 4'd7,
    PLAN_ROWS_SPLIT   = 4'd8,
    PLAN_SMALL_ROWS   = 4'd9
  } plan_e;

  typedef struct packed {
    logic [AddrW-1:0] src_address;
    logic [AddrW-1:0] dst_address;
    logic [DimW-1:0]  src_pitch;
    logic [DimW-1:0]  dst_pitch;
    logic [DimW-1:0]  row_width;
    logic [DimW-1:0]  row_count;
    logic             src_external;
    logic             dst_external;
    logic             src_reachable;
    logic             dst_reachable;
  } req_t;

  typedef struct packed {
    logic [PlanW-1:0]  plan;
    logic [AddrW-1:0]  dma_src_address;
    logic [AddrW-1:0]  dma_dst_address;
    logic [AddrW-1:0]  dma_bytes;
    logic [DimW-1:0]   xfer_rows;
    logic [SplitW-1:0] head_bytes;
    logic [SplitW-1:0] tail_bytes;
  } res_t;

  typedef struct packed {
    logic            engine_on;
    logic [DimW-1:0] min_row;
  } cfg_t;

endpackage

[hdl/bdpp_plan.sv]
module bdpp_plan (
  input  bdpp_pkg::req_t               req_i,
  input  logic [bdpp_pkg::AddrW-1:0]   total_i,
  input  bdpp_pkg::cfg_t               cfg_i,
  output bdpp_pkg::res_t               res_o
);

  // True when x is a multiple of the alignment that applies to this request.
  function automatic logic is_aligned(input logic [bdpp_pkg::AddrW-1:0] x,
                                      input logic ext);
    logic res;
    if (ext) begin
      res = (x[bdpp_pkg::ExtAlignLg-1:0] == '0);
    end else begin
      res = (x[bdpp_pkg::IntAlignLg-1:0] == '0);
    end
    return res;
  endfunction

  logic                              ext;
  logic                              capable;
  logic                              contig;
  logic                              no_req;
  logic [bdpp_pkg::AddrW-1:0]        n;
  logic [bdpp_pkg::ExtAlignLg-1:0]   s_lo;
  logic [bdpp_pkg::ExtAlignLg-1:0]   d_lo;
  logic                              same_mod;
  logic [bdpp_pkg::ExtAlignLg-1:0]   head;
  logic [bdpp_pkg::AddrW-1:0]        head_w;
  logic [bdpp_pkg::AddrW-1:0]        rest;
  logic [bdpp_pkg::ExtAlignLg-1:0]   tail;
  logic [bdpp_pkg::AddrW-1:0]        mid;
  logic [bdpp_pkg::AddrW-1:0]        mid_src;
  logic [bdpp_pkg::AddrW-1:0]        mid_dst;
  logic                              splittable;
  logic                              ok_whole;
  logic                              ok_split;
  logic                              strides_ok;

  // Request classification.
  assign ext     = req_i.src_external | req_i.dst_external;
  assign capable = req_i.src_reachable & req_i.dst_reachable;
  assign contig  = (req_i.src_pitch == req_i.row_width) &&
                   (req_i.dst_pitch == req_i.row_width);
  assign no_req  = (req_i.src_address == '0) || (req_i.dst_address == '0) ||
                   (req_i.row_width == '0) || (req_i.row_count == '0);

  // Contiguous copies move the whole area at once, row-wise copies one row.
  assign n = contig ? total_i : bdpp_pkg::AddrW'(req_i.row_width);

  // Head, middle and tail split on the external alignment.
  assign s_lo     = req_i.src_address[bdpp_pkg::ExtAlignLg-1:0];
  assign d_lo     = req_i.dst_address[bdpp_pkg::ExtAlignLg-1:0];
  assign same_mod = (s_lo == d_lo);
  assign head     = '0 - s_lo;
  assign head_w   = bdpp_pkg::AddrW'(head);
  assign rest     = n - head_w;
  assign tail     = rest[bdpp_pkg::ExtAlignLg-1:0];
  assign mid      = {rest[bdpp_pkg::AddrW-1:bdpp_pkg::ExtAlignLg],
                     {bdpp_pkg::ExtAlignLg{1'b0}}};
  assign mid_src  = req_i.src_address + head_w;
  assign mid_dst  = req_i.dst_address + head_w;

  assign splittable = (n != '0) && same_mod && (head_w <= n) && (mid != '0);

  // DMA suitability of the whole range and of the middle part.
  assign ok_whole = (n != '0) && capable &&
                    is_aligned(req_i.src_address, ext) &&
                    is_aligned(req_i.dst_address, ext) && is_aligned(n, ext);
  assign ok_split = splittable && capable && is_aligned(mid_src, ext) &&
                    is_aligned(mid_dst, ext) && is_aligned(mid, ext);
  assign strides_ok = contig ||
                      (is_aligned(bdpp_pkg::AddrW'(req_i.src_pitch), ext) &&
                       is_aligned(bdpp_pkg::AddrW'(req_i.dst_pitch), ext));

  // Plan selection and result fields; software plans leave the DMA part empty.
  always_comb begin
    res_o = '0;
    if (no_req) begin
      res_o.plan = bdpp_pkg::PLAN_IGNORED;
    end else if (!cfg_i.engine_on) begin
      res_o.plan = bdpp_pkg::PLAN_NO_ENGINE;
    end else if (!contig && (req_i.row_width < cfg_i.min_row)) begin
      res_o.plan = bdpp_pkg::PLAN_NARROW_ROW;
    end else if (ok_whole && strides_ok) begin
      res_o.plan            = contig ? bdpp_pkg::PLAN_DMA_CONTIG
                                     : bdpp_pkg::PLAN_ROW_DMA;
      res_o.dma_src_address = req_i.src_address;
      res_o.dma_dst_address = req_i.dst_address;
      res_o.dma_bytes       = n;
      res_o.xfer_rows       = contig ? '0 : req_i.row_count;
    end else if (ok_split && strides_ok) begin
      res_o.plan            = contig ? bdpp_pkg::PLAN_CONTIG_SPLIT
                                     : bdpp_pkg::PLAN_ROWS_SPLIT;
      res_o.dma_src_address = mid_src;
      res_o.dma_dst_address = mid_dst;
      res_o.dma_bytes       = mid;
      res_o.xfer_rows       = contig ? '0 : req_i.row_count;
      res_o.head_bytes      = head_w[bdpp_pkg::SplitW-1:0];
      res_o.tail_bytes      = tail;
    end else if (same_mod && !splittable) begin
      res_o.plan = contig ? bdpp_pkg::PLAN_SMALL_CONTIG
                          : bdpp_pkg::PLAN_SMALL_ROWS;
    end else begin
      res_o.plan = bdpp_pkg::PLAN_MISALIGNED;
    end
  end

endmodule

[hdl/blit_dma_path_planner.sv]
// Plans 2D copy requests, one per clock cycle when the output keeps up. A
// request is held in an input register, the plan logic works on it
// combinationally, including the 16 x 16 product of row width and row count
// for contiguous copies, and the plan is held in a result register. A plan
// is offered from the result register once its request moves on from the
// input register, and the input stalls only while both registers are full
// and the output is stalled. Requests whose strides both equal the row width
// are contiguous; DMA alignment is 32 bytes when either side is external and
// 16 bytes otherwise, while the head and tail split always uses 32. There is
// no state between requests; the two configuration registers are read by
// every plan and should be written only while no request is in flight.
module blit_dma_path_planner (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bdpp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bdpp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bdpp_pkg::req_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bdpp_pkg::res_t                  out_data_o
);

  bdpp_pkg::cfg_t             cfg_q;
  logic                       s1_valid_q;
  bdpp_pkg::req_t             s1_q;
  logic [bdpp_pkg::AddrW-1:0] total_d;
  logic                       out_valid_q;
  bdpp_pkg::res_t             res_d;
  bdpp_pkg::res_t             out_q;
  logic                       out_ready;
  logic                       s1_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.engine_on <= 1'b1;
      cfg_q.min_row   <= bdpp_pkg::MinRowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bdpp_pkg::CFG_ENGINE:  cfg_q.engine_on <= cfg_data_i[0];
        bdpp_pkg::CFG_MIN_ROW: cfg_q.min_row   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Each stage moves on when the stage after it is empty or moving too.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Area of the request in bytes, fed straight into the plan logic.
  assign total_d = bdpp_pkg::AddrW'(s1_q.row_width) * bdpp_pkg::AddrW'(s1_q.row_count);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q <= in_data_i;
    end
    if (s1_valid_q && out_ready) begin
      out_q <= res_d;
    end
  end

  bdpp_plan u_plan (
    .req_i   (s1_q),
    .total_i (total_d),
    .cfg_i   (cfg_q),
    .res_o   (res_d)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/bdpp_checker.sv]
`include "blit_dma_path_planner_defines.svh"

module bdpp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input bdpp_pkg::res_t out_data_o
);

  logic sw_plan;
  logic whole_plan;
  logic split_plan;
  logic stalled;
  logic dma_empty;
  logic whole_ok;
  logic mid_ok;

  // Plans that leave all work to software.
  assign sw_plan = (out_data_o.plan == bdpp_pkg::PLAN_IGNORED) ||
                   (out_data_o.plan == bdpp_pkg::PLAN_NO_ENGINE) ||
                   (out_data_o.plan == bdpp_pkg::PLAN_SMALL_CONTIG) ||
                   (out_data_o.plan == bdpp_pkg::PLAN_MISALIGNED) ||
                   (out_data_o.plan == bdpp_pkg::PLAN_NARROW_ROW) ||
                   (out_data_o.plan == bdpp_pkg::PLAN_SMALL_ROWS);
  assign whole_plan = (out_data_o.plan == bdpp_pkg::PLAN_DMA_CONTIG) ||
                      (out_data_o.plan == bdpp_pkg::PLAN_ROW_DMA);
  assign split_plan = (out_data_o.plan == bdpp_pkg::PLAN_CONTIG_SPLIT) ||
                      (out_data_o.plan == bdpp_pkg::PLAN_ROWS_SPLIT);

  // Field conditions that each kind of plan must meet.
  assign stalled   = out_valid_o && out_stall_i;
  assign dma_empty = (out_data_o.dma_bytes == '0) && (out_data_o.xfer_rows == '0) &&
                     (out_data_o.head_bytes == '0) && (out_data_o.tail_bytes == '0);
  assign whole_ok  = (out_data_o.head_bytes == '0) && (out_data_o.tail_bytes == '0) &&
                     (out_data_o.dma_bytes != '0);
  assign mid_ok    = (out_data_o.dma_src_address[bdpp_pkg::ExtAlignLg-1:0] == '0) &&
                     (out_data_o.dma_bytes != '0);

  `BDPP_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result during reset")
  `BDPP_ASSERT(a_result_held, stalled |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `BDPP_ASSERT(a_sw_plan_empty, out_valid_o && sw_plan |-> dma_empty, "software plan with DMA fields")
  `BDPP_ASSERT(a_whole_no_split, out_valid_o && whole_plan |-> whole_ok, "whole DMA plan malformed")
  `BDPP_ASSERT(a_split_aligned, out_valid_o && split_plan |-> mid_ok, "split plan middle unaligned")

endmodule

bind blit_dma_path_planner bdpp_checker u_bdpp_checker (.*);

[tb/blit_dma_path_planner_test.sv]
module blit_dma_path_planner_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] INT_ALIGN = 64'd1 << bdpp_pkg::IntAlignLg;
  localparam logic [63:0] EXT_ALIGN = 64'd1 << bdpp_pkg::ExtAlignLg;
  localparam int unsigned PIPE_DEPTH = 2;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned IDLE_PCT = 38;
  localparam int unsigned PHASES = 7;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_e;

  // One line of the directed table: either a register update or a request.
  typedef struct packed {
    row_kind_e                     kind;
    logic [bdpp_pkg::CfgDataW-1:0] engine_word;
    logic [bdpp_pkg::CfgDataW-1:0] min_row_word;
    bdpp_pkg::req_t                req;
    logic                          typed;
    bdpp_pkg::res_t                typed_plan;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i = 1'b0;
  logic [bdpp_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [bdpp_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  bdpp_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bdpp_pkg::res_t out_data_o;

  // Register values as the block should currently see them.
  logic engine_model = 1'b1;
  logic [bdpp_pkg::DimW-1:0] min_row_model = bdpp_pkg::MinRowReset;

  bdpp_pkg::res_t plans_due[$];
  stim_row_t directed_rows[$];
  logic no_idle = 1'b0;
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned settings = 0;
  int unsigned idle_cycles = 0;
  int unsigned plan_hits[16];
  bdpp_pkg::res_t want;

  logic [bdpp_pkg::CfgDataW-1:0] phase_engine[PHASES] =
    '{16'h0001, 16'h8001, 16'hFFFE, 16'h0003, 16'h0001, 16'h7FFF, 16'h0001};
  logic [bdpp_pkg::CfgDataW-1:0] phase_min_row[PHASES] =
    '{16'd128, 16'd1, 16'd128, 16'hFFFF, 16'd0, 16'd32, 16'd128};
  int unsigned phase_items[PHASES] = '{250, 250, 100, 150, 200, 250, 250};

  blit_dma_path_planner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // A DMA transfer needs both ends, the length and reachability to line up.
  function automatic logic dma_fits(input logic [63:0] s, d, n, algn, input logic capable);
    return (n != 0) && (s % algn == 0) && (d % algn == 0) && (n % algn == 0) && capable;
  endfunction

  // Cuts a span into a software head, an aligned middle and a software tail.
  function automatic logic split_span(input logic [63:0] s, d, n,
                                      output logic [63:0] head, mid, tail);
    logic [63:0] h;
    head = '0;
    mid = '0;
    tail = '0;
    if (n == 0 || (s % EXT_ALIGN) != (d % EXT_ALIGN)) return 1'b0;
    h = (EXT_ALIGN - s % EXT_ALIGN) % EXT_ALIGN;
    if (h > n) return 1'b0;
    head = h;
    tail = (n - h) % EXT_ALIGN;
    mid = n - h - tail;
    return mid != 0;
  endfunction

  // Works out the copy plan for one request under the current register values.
  function automatic bdpp_pkg::res_t plan_copy(input bdpp_pkg::req_t r);
    logic [63:0] s, d, ss, ds, w, n, algn, span, rows, head, mid, tail, s_mid, d_mid;
    logic capable, same_mod, contiguous, strides, splittable;
    bdpp_pkg::res_t p;
    s = 64'(r.src_address);
    d = 64'(r.dst_address);
    ss = 64'(r.src_pitch);
    ds = 64'(r.dst_pitch);
    w = 64'(r.row_width);
    n = 64'(r.row_count);
    capable = r.src_reachable & r.dst_reachable;
    algn = (r.src_external | r.dst_external) ? EXT_ALIGN : INT_ALIGN;
    same_mod = (s % EXT_ALIGN) == (d % EXT_ALIGN);
    contiguous = (ss == w) && (ds == w);
    p = '0;
    if (s == 0 || d == 0 || w == 0 || n == 0) begin
      p.plan = bdpp_pkg::PLAN_IGNORED;
    end else if (!engine_model) begin
      p.plan = bdpp_pkg::PLAN_NO_ENGINE;
    end else if (!contiguous && w < 64'(min_row_model)) begin
      p.plan = bdpp_pkg::PLAN_NARROW_ROW;
    end else begin
      // A contiguous request is one long span; a row-wise one repeats per row.
      span = contiguous ? w * n : w;
      rows = contiguous ? 64'd0 : n;
      strides = contiguous || ((ss % algn == 0) && (ds % algn == 0));
      if (dma_fits(s, d, span, algn, capable) && strides) begin
        p.plan = contiguous ? bdpp_pkg::PLAN_DMA_CONTIG : bdpp_pkg::PLAN_ROW_DMA;
        p.dma_src_address = s[31:0];
        p.dma_dst_address = d[31:0];
        p.dma_bytes = span[31:0];
        p.xfer_rows = rows[15:0];
      end else begin
        splittable = split_span(s, d, span, head, mid, tail);
        s_mid = (s + head) & 64'hFFFF_FFFF;
        d_mid = (d + head) & 64'hFFFF_FFFF;
        if (splittable && strides && dma_fits(s_mid, d_mid, mid, algn, capable)) begin
          p.plan = contiguous ? bdpp_pkg::PLAN_CONTIG_SPLIT : bdpp_pkg::PLAN_ROWS_SPLIT;
          p.dma_src_address = s_mid[31:0];
          p.dma_dst_address = d_mid[31:0];
          p.dma_bytes = mid[31:0];
          p.xfer_rows = rows[15:0];
          p.head_bytes = head[4:0];
          p.tail_bytes = tail[4:0];
        end else if (same_mod && !splittable) begin
          p.plan = contiguous ? bdpp_pkg::PLAN_SMALL_CONTIG : bdpp_pkg::PLAN_SMALL_ROWS;
        end else begin
          p.plan = bdpp_pkg::PLAN_MISALIGNED;
        end
      end
    end
    return p;
  endfunction

  function automatic bdpp_pkg::req_t copy_req(input logic [31:0] s, d,
                                              input logic [15:0] ss, ds, w, n,
                                              input logic [3:0] flags);
    bdpp_pkg::req_t r;
    r = '0;
    r.src_address = s;
    r.dst_address = d;
    r.src_pitch = ss;
    r.dst_pitch = ds;
    r.row_width = w;
    r.row_count = n;
    {r.src_external, r.dst_external, r.src_reachable, r.dst_reachable} = flags;
    return r;
  endfunction

  function automatic bdpp_pkg::res_t bare_plan(input bdpp_pkg::plan_e p);
    bdpp_pkg::res_t e;
    e = '0;
    e.plan = p;
    return e;
  endfunction

  function automatic bdpp_pkg::res_t dma_plan(input bdpp_pkg::plan_e p,
                                              input logic [31:0] ms, md, nb,
                                              input logic [4:0] hb, tb);
    bdpp_pkg::res_t e;
    e = bare_plan(p);
    e.dma_src_address = ms;
    e.dma_dst_address = md;
    e.dma_bytes = nb;
    e.head_bytes = hb;
    e.tail_bytes = tb;
    return e;
  endfunction

  function automatic stim_row_t request_row(input bdpp_pkg::req_t r);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.req = r;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input bdpp_pkg::req_t r, input bdpp_pkg::res_t e);
    stim_row_t row;
    row = request_row(r);
    row.typed = 1'b1;
    row.typed_plan = e;
    return row;
  endfunction

  function automatic stim_row_t config_row(input logic [bdpp_pkg::CfgDataW-1:0] eng, mrow);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CONFIG;
    row.engine_word = eng;
    row.min_row_word = mrow;
    return row;
  endfunction

  // Mostly requests with chosen alignments, widths and strides; some pure noise.
  function automatic bdpp_pkg::req_t random_request();
    bdpp_pkg::req_t r;
    logic [31:0] a, b, c, e, f;
    logic [15:0] w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    a = $urandom();
    b = $urandom();
    c = $urandom();
    e = $urandom();
    f = $urandom();
    r = {a, b, c, e, f[3:0]};
    if (pick < 10) return r;
    // Low address bits decide alignment and whether a split is possible.
    case (f[5:4])
      2'd0: begin
        r.src_address[4:0] = '0;
        r.dst_address[4:0] = '0;
      end
      2'd3: begin
        r.src_address[4:0] = f[10:6];
        r.dst_address[4:0] = f[15:11];
      end
      default: begin
        r.src_address[4:0] = f[10:6];
        r.dst_address[4:0] = f[10:6];
      end
    endcase
    // Near the top of the map the address after the head bytes can wrap.
    if (f[18:16] == 3'd0) r.src_address[31:12] = '1;
    case (f[23:21])
      3'd0: w = 16'($urandom_range(1, 40));
      3'd1: w = 16'($urandom_range(1, 300));
      3'd2: w = {6'd0, e[4:0], 5'd0};
      3'd3: w = {5'd0, e[6:0], 4'd0};
      3'd4: w = 16'(min_row_model + 16'($urandom_range(0, 2)) - 16'd1);
      3'd5: w = e[15:0];
      default: w = 16'($urandom_range(100, 1100));
    endcase
    r.row_width = w;
    r.row_count = f[24] ? 16'($urandom_range(1, 12)) : e[31:16];
    if (f[27:25] != 3'd0) {r.src_reachable, r.dst_reachable} = 2'b11;
    case (f[30:28]) inside
      [3'd0:3'd2]: begin
        r.src_pitch = w;
        r.dst_pitch = w;
      end
      3'd3: begin
        r.src_pitch = w + {3'd0, c[7:0], 5'd0};
        r.dst_pitch = w + {3'd0, c[23:16], 5'd0};
      end
      3'd4: begin
        r.src_pitch = w;
        r.dst_pitch = w + {4'd0, c[23:16], 4'd0};
      end
      3'd5: begin
        r.src_pitch = {c[10:0], 5'd0};
        r.dst_pitch = {c[26:16], 5'd0};
      end
      default: ;
    endcase
    // A few requests with a zero field, which the block ignores.
    case (pick)
      10: r.src_address = '0;
      11: r.dst_address = '0;
      12: r.row_width = '0;
      13: r.row_count = '0;
      default: ;
    endcase
    return r;
  endfunction

  // Holds the request back until every outstanding plan has come out.
  task automatic drain_plans();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (plans_due.size() != 0);
  endtask

  // Updates both registers while the block is idle.
  task automatic apply_config(input logic [bdpp_pkg::CfgDataW-1:0] eng, mrow);
    drain_plans();
    cfg_we_i <= 1'b1;
    cfg_index_i <= bdpp_pkg::CFG_ENGINE;
    cfg_data_i <= eng;
    @(posedge clk_i);
    cfg_index_i <= bdpp_pkg::CFG_MIN_ROW;
    cfg_data_i <= mrow;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    engine_model = eng[0];
    min_row_model = mrow;
    settings++;
  endtask

  // Offers one request, with random gaps, and records its plan on transfer.
  task automatic send_request(input bdpp_pkg::req_t r, input logic typed,
                              input bdpp_pkg::res_t typed_plan);
    bdpp_pkg::res_t p;
    p = typed ? typed_plan : plan_copy(r);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    plans_due.push_back(p);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_val, got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // The receiver stalls at random except during the calm phase.
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Every plan that transfers out is checked against the oldest one due.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (plans_due.size() == 0) begin
        $display("%0t: unexpected plan: expected none, got %0h", $time, out_data_o);
        mismatches++;
      end else begin
        want = plans_due.pop_front();
        compare_field("plan", 32'(want.plan), 32'(out_data_o.plan));
        compare_field("dma_src_address", want.dma_src_address, out_data_o.dma_src_address);
        compare_field("dma_dst_address", want.dma_dst_address, out_data_o.dma_dst_address);
        compare_field("dma_bytes", want.dma_bytes, out_data_o.dma_bytes);
        compare_field("xfer_rows", 32'(want.xfer_rows), 32'(out_data_o.xfer_rows));
        compare_field("head_bytes", 32'(want.head_bytes), 32'(out_data_o.head_bytes));
        compare_field("tail_bytes", 32'(want.tail_bytes), 32'(out_data_o.tail_bytes));
        plan_hits[want.plan]++;
        checked++;
      end
    end
  end

  // Ends a run in which no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("** blit_dma_path_planner: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    // Reset values: ignored requests and zero fields.
    directed_rows.push_back(typed_row(copy_req(32'h0, 32'h2000, 16'd64, 16'd64, 16'd64,
                                               16'd4, 4'b0011),
                                      bare_plan(bdpp_pkg::PLAN_IGNORED)));
    directed_rows.push_back(typed_row(copy_req(32'h1000, 32'h0, 16'd64, 16'd64, 16'd64,
                                               16'd4, 4'b0011),
                                      bare_plan(bdpp_pkg::PLAN_IGNORED)));
    directed_rows.push_back(typed_row(copy_req(32'h1000, 32'h2000, 16'd64, 16'd64, 16'd0,
                                               16'd4, 4'b0011),
                                      bare_plan(bdpp_pkg::PLAN_IGNORED)));
    directed_rows.push_back(typed_row(copy_req(32'h1000, 32'h2000, 16'd64, 16'd64, 16'd64,
                                               16'd0, 4'b0011),
                                      bare_plan(bdpp_pkg::PLAN_IGNORED)));
    // All fields at their maximum: split with the DMA start wrapping to zero.
    directed_rows.push_back(typed_row(copy_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                               16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111),
                                      dma_plan(bdpp_pkg::PLAN_CONTIG_SPLIT, 32'h0, 32'h0,
                                               32'hFFFE_0000, 5'd1, 5'd0)));
    // Contiguous cases.
    directed_rows.push_back(typed_row(copy_req(32'h1000, 32'h2000, 16'd64, 16'd64, 16'd64,
                                               16'd4, 4'b0011),
                                      dma_plan(bdpp_pkg::PLAN_DMA_CONTIG, 32'h1000, 32'h2000,
                                               32'd256, 5'd0, 5'd0)));
    directed_rows.push_back(request_row(copy_req(32'h1000, 32'h2000, 16'd64, 16'd64, 16'd64,
                                                 16'd4, 4'b0001)));
    directed_rows.push_back(request_row(copy_req(32'h1003, 32'h2003, 16'd100, 16'd100,
                                                 16'd100, 16'd3, 4'b0011)));
    directed_rows.push_back(typed_row(copy_req(32'h1003, 32'h2003, 16'd10, 16'd10, 16'd10,
                                               16'd1, 4'b0011),
                                      bare_plan(bdpp_pkg::PLAN_SMALL_CONTIG)));
    directed_rows.push_back(typed_row(copy_req(32'h1001, 32'h2002, 16'd64, 16'd64, 16'd64,
                                               16'd4, 4'b0011),
                                      bare_plan(bdpp_pkg::PLAN_MISALIGNED)));
    // Row-wise cases.
    directed_rows.push_back(typed_row(copy_req(32'h1000, 32'h2000, 16'd256, 16'd256, 16'd64,
                                               16'd4, 4'b0011),
                                      bare_plan(bdpp_pkg::PLAN_NARROW_ROW)));
    directed_rows.push_back(request_row(copy_req(32'h10000, 32'h20000, 16'd512, 16'd512,
                                                 16'd256, 16'd8, 4'b1011)));
    directed_rows.push_back(request_row(copy_req(32'h10005, 32'h20005, 16'd512, 16'd512,
                                                 16'd300, 16'd5, 4'b0111)));
    directed_rows.push_back(request_row(copy_req(32'h10005, 32'h20005, 16'd520, 16'd512,
                                                 16'd300, 16'd5, 4'b1111)));
    directed_rows.push_back(request_row(copy_req(32'h1010, 32'h2010, 16'd160, 16'd160,
                                                 16'd144, 16'd2, 4'b0011)));
    directed_rows.push_back(request_row(copy_req(32'h1000, 32'h2000, 16'd0, 16'd0, 16'd128,
                                                 16'd3, 4'b0011)));
    directed_rows.push_back(request_row(copy_req(32'h1000, 32'h2000, 16'd256, 16'd512,
                                                 16'd256, 16'd2, 4'b0011)));
    directed_rows.push_back(request_row(copy_req(32'h1001, 32'h2002, 16'd256, 16'd256,
                                                 16'd200, 16'd2, 4'b0011)));
    directed_rows.push_back(request_row(copy_req(32'h1000, 32'h2000, 16'd256, 16'd256,
                                                 16'd256, 16'd2, 4'b0001)));
    directed_rows.push_back(request_row(copy_req(32'hFFFF_FFF8, 32'h7FFF_FFF8, 16'd1024,
                                                 16'd1024, 16'd512, 16'd2, 4'b0011)));
    // Smallest row limit lets a short strided row reach the small-rows plan.
    directed_rows.push_back(config_row(16'h0001, 16'd1));
    directed_rows.push_back(typed_row(copy_req(32'h10005, 32'h20005, 16'd64, 16'd64, 16'd20,
                                               16'd3, 4'b0011),
                                      bare_plan(bdpp_pkg::PLAN_SMALL_ROWS)));
    // Largest row limit: only a full-width row is wide enough.
    directed_rows.push_back(config_row(16'h0001, 16'hFFFF));
    directed_rows.push_back(typed_row(copy_req(32'h1000, 32'h2000, 16'd0, 16'd0, 16'hFFFE,
                                               16'd1, 4'b0011),
                                      bare_plan(bdpp_pkg::PLAN_NARROW_ROW)));
    directed_rows.push_back(request_row(copy_req(32'h1000, 32'h2000, 16'd0, 16'd0, 16'hFFFF,
                                                 16'd1, 4'b0011)));
    // Engine absent.
    directed_rows.push_back(config_row(16'h0000, 16'd128));
    directed_rows.push_back(typed_row(copy_req(32'h1000, 32'h2000, 16'd64, 16'd64, 16'd64,
                                               16'd4, 4'b0011),
                                      bare_plan(bdpp_pkg::PLAN_NO_ENGINE)));
    directed_rows.push_back(typed_row(copy_req(32'h1000, 32'h2000, 16'd64, 16'd64, 16'd64,
                                               16'd0, 4'b0011),
                                      bare_plan(bdpp_pkg::PLAN_IGNORED)));
    phase_min_row[PHASES-1] = 16'($urandom_range(1, 65535));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        apply_config(directed_rows[i].engine_word, directed_rows[i].min_row_word);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].typed,
                     directed_rows[i].typed_plan);
      end
    end

    // Random phases, each under its own register setting; the first runs without gaps.
    for (int ph = 0; ph < PHASES; ph++) begin
      apply_config(phase_engine[ph], phase_min_row[ph]);
      no_idle = (ph == 0);
      for (int unsigned k = 0; k < phase_items[ph]; k++) begin
        send_request(random_request(), 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    drain_plans();
    repeat (PIPE_DEPTH + 5) @(posedge clk_i);
    $display("Checked %0d plans from a directed table and %0d random phases, %0d settings.",
             checked, PHASES, settings);
    $display("Plans seen: %0d ignored, %0d software, %0d whole DMA, %0d split DMA.",
             plan_hits[bdpp_pkg::PLAN_IGNORED],
             plan_hits[bdpp_pkg::PLAN_NO_ENGINE] + plan_hits[bdpp_pkg::PLAN_SMALL_CONTIG] +
             plan_hits[bdpp_pkg::PLAN_MISALIGNED] + plan_hits[bdpp_pkg::PLAN_NARROW_ROW] +
             plan_hits[bdpp_pkg::PLAN_SMALL_ROWS],
             plan_hits[bdpp_pkg::PLAN_DMA_CONTIG] + plan_hits[bdpp_pkg::PLAN_ROW_DMA],
             plan_hits[bdpp_pkg::PLAN_CONTIG_SPLIT] + plan_hits[bdpp_pkg::PLAN_ROWS_SPLIT]);
    if (mismatches == 0) begin
      $display("** blit_dma_path_planner: PASSED **");
    end else begin
      $display("** blit_dma_path_planner: FAILED **");
    end
    $finish;
  end

endmodule
